// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the IR gap decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define CHK_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== sv/irgap_pkg.sv =====
// ----------------------------------------------------------------------------
// IR gap decoder package
// Widths and reset values shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package irgap_pkg;

	// Field and register widths.
	localparam int CFG_W   = 12;
	localparam int CFG_N   = 8;
	localparam int CFG_IDX_W = 3;
	localparam int BYTE_W  = 8;
	localparam int TICK_W  = 14;
	localparam int CNT_W   = 4;

	// Default timing parameters.
	localparam int DEF_TIMEOUT_TICKS = 10000;
	localparam int DEF_GAP_SHIFT     = 4;

	// Threshold register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREAMBLE_ABOVE = 3'd0,
		REG_PREAMBLE_BELOW = 3'd1,
		REG_BIT_FLOOR      = 3'd2,
		REG_BIT_CEILING    = 3'd3,
		REG_ONE_ABOVE      = 3'd4,
		REG_ONE_BELOW      = 3'd5,
		REG_END_ABOVE      = 3'd6,
		REG_END_BELOW      = 3'd7
	} cfg_reg_t;

	// Threshold reset values, in register index order.
	localparam logic [CFG_W-1:0] CFG_RESET [CFG_N] = '{
		12'd250, 12'd500, 12'd10, 12'd60, 12'd30, 12'd50, 12'd50, 12'd80
	};

endpackage

// ===== sv/ir_gap_length_byte_decoder.sv =====
// ----------------------------------------------------------------------------
// IR gap-length byte decoder
// Times high gaps on a sampled IR receiver line and decodes framed bytes.
// ----------------------------------------------------------------------------
// Each input beat is one receiver sample taken on a timer tick (0 pulse,
// 1 gap). The block takes one sample every clock cycle: the gap timer, the
// threshold compares and the byte shifter update in the cycle the beat is
// accepted, and a decoded byte appears in the output register in the cycle
// after the sample whose falling edge ends a valid end gap. The input side
// stalls only while a finished byte sits in the output register and the
// output is not ready. A gap length is divided by 2**GAP_SHIFT before it is
// compared against the eight 12-bit thresholds; any pulse or gap that runs
// past TIMEOUT_TICKS samples sends the decoder back to waiting for a
// preamble. Write thresholds through the cfg port only while idle (unenforced).
module ir_gap_length_byte_decoder #(
	parameter int TIMEOUT_TICKS = irgap_pkg::DEF_TIMEOUT_TICKS,
	parameter int GAP_SHIFT     = irgap_pkg::DEF_GAP_SHIFT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            rx_level,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [irgap_pkg::BYTE_W-1:0]    byte_value,
	input  logic                            cfg_we,
	input  logic [irgap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [irgap_pkg::CFG_W-1:0]     cfg_data
);
	import irgap_pkg::*;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_BITS = 2'd1,
		PH_END  = 2'd2
	} phase_t;

	localparam logic [TICK_W-1:0] TIMEOUT_L = TICK_W'(TIMEOUT_TICKS);
	localparam logic [CNT_W-1:0]  BITS_PER_BYTE = CNT_W'(BYTE_W);

	logic [CFG_W-1:0]  cfg_q [CFG_N];
	phase_t            phase_q, phase_n;
	logic [BYTE_W-1:0] shift_q, shift_n;
	logic [CNT_W-1:0]  bits_q, bits_n;
	logic [TICK_W-1:0] tick_q, tick_n;
	logic              last_q, last_n;
	logic              armed_q, armed_n;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;

	logic              accept;
	logic              res_valid;
	logic [TICK_W-1:0] scaled;
	logic              one_bit;
	logic [CNT_W-1:0]  bits_inc;

	assign in_ready   = !out_valid_q || out_ready;
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign byte_value = byte_q;

	// Scaled gap length and the window tests that depend on it.
	assign scaled   = tick_q >> GAP_SHIFT;
	assign one_bit  = (scaled > TICK_W'(cfg_q[REG_ONE_ABOVE])) &&
	                  (scaled < TICK_W'(cfg_q[REG_ONE_BELOW]));
	assign bits_inc = bits_q + CNT_W'(1);

	// Next-state logic for one receiver sample.
	always_comb begin
		phase_n   = phase_q;
		shift_n   = shift_q;
		bits_n    = bits_q;
		tick_n    = tick_q;
		last_n    = rx_level;
		armed_n   = armed_q;
		res_valid = 1'b0;
		if (rx_level != last_q) begin
			if (!rx_level) begin
				// Falling edge closes a gap; classify it if it was timed.
				if (armed_q) begin
					case (phase_q)
						PH_BITS: begin
							if ((scaled > TICK_W'(cfg_q[REG_BIT_CEILING])) ||
							    (scaled < TICK_W'(cfg_q[REG_BIT_FLOOR]))) begin
								phase_n = PH_WAIT;
							end else begin
								shift_n = {shift_q[BYTE_W-2:0], one_bit};
								bits_n  = bits_inc;
								if (bits_inc >= BITS_PER_BYTE) begin
									phase_n = PH_END;
								end
							end
						end
						PH_END: begin
							if ((scaled > TICK_W'(cfg_q[REG_END_ABOVE])) &&
							    (scaled < TICK_W'(cfg_q[REG_END_BELOW]))) begin
								res_valid = 1'b1;
								phase_n   = PH_BITS;
								shift_n   = '0;
								bits_n    = '0;
							end else begin
								phase_n = PH_WAIT;
							end
						end
						default: begin
							if ((scaled > TICK_W'(cfg_q[REG_PREAMBLE_ABOVE])) &&
							    (scaled < TICK_W'(cfg_q[REG_PREAMBLE_BELOW]))) begin
								phase_n = PH_BITS;
								shift_n = '0;
								bits_n  = '0;
							end else begin
								phase_n = PH_WAIT;
							end
						end
					endcase
				end
				armed_n = 1'b1;
			end
			tick_n = TICK_W'(1);
		end else if (!rx_level || armed_q) begin
			// Same level: extend the phase timer, or time out.
			if (tick_q >= TIMEOUT_L) begin
				tick_n  = TIMEOUT_L;
				phase_n = PH_WAIT;
				if (rx_level) begin
					armed_n = 1'b0;
				end
			end else begin
				tick_n = tick_q + TICK_W'(1);
			end
		end
	end

	// Threshold registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	// Decoder state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT;
			shift_q     <= '0;
			bits_q      <= '0;
			tick_q      <= '0;
			last_q      <= 1'b1;
			armed_q     <= 1'b0;
			out_valid_q <= 1'b0;
			byte_q      <= '0;
		end else begin
			// A new byte takes the output register; otherwise a taken beat empties it.
			if (accept && res_valid) begin
				out_valid_q <= 1'b1;
				byte_q      <= shift_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				phase_q <= phase_n;
				shift_q <= shift_n;
				bits_q  <= bits_n;
				tick_q  <= tick_n;
				last_q  <= last_n;
				armed_q <= armed_n;
			end
		end
	end

endmodule

// ===== sv/irgap_checker.sv =====
// ----------------------------------------------------------------------------
// IR gap decoder checker
// Port-level assertions on the decoder's handshakes and result timing.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module irgap_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            rx_level,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [irgap_pkg::BYTE_W-1:0]    byte_value,
	input logic                            cfg_we
);
	import irgap_pkg::*;

	logic [BYTE_W-1:0] byte_seen;

	assign byte_seen = byte_value;

	// A byte that is not taken stays on the output unchanged.
	`CHK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(byte_seen), "output beat changed while stalled")

	// The input side only stalls while a result is held back.
	`CHK_NEVER(a_stall_cause, !in_ready && !(out_valid && !out_ready), "input stalled without a pending result")

	// A new byte follows an accepted low sample, which closes the end gap.
	`CHK_ASSERT(a_byte_cause, $rose(out_valid) |-> $past(in_valid && in_ready && !rx_level), "byte without a closing pulse")

	// A configuration write never produces a byte by itself.
	`CHK_ASSERT(a_cfg_quiet, cfg_we && !(in_valid && in_ready) && !out_valid |=> !out_valid, "byte after a register write alone")

endmodule

bind ir_gap_length_byte_decoder irgap_checker u_irgap_checker (.*);
